[rtl/mcc_pkg.sv]
// Package for the MIDI controller value cache: sizes, codes and word types.
`timescale 1ns / 1ps

package mcc_pkg;

  // Number of streams with a table set of their own
  localparam int NUM_STREAMS = 4;

  // One table slot per map entry: 512 slots per stream, 288 of them used
  localparam int ENTRY_W   = 9;
  localparam int STREAM_W  = 2;
  localparam int MEM_DEPTH = NUM_STREAMS * (1 << ENTRY_W);
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int VALUE_W   = 16;

  // Map layout
  localparam logic [ENTRY_W-1:0] ENTRY_KEY  = 9'd128;
  localparam logic [ENTRY_W-1:0] ENTRY_CHAN = 9'd256;
  localparam logic [ENTRY_W-1:0] ENTRY_BEND = 9'd272;
  localparam logic [ENTRY_W-1:0] ENTRY_MAX  = 9'd287;

  // Message kinds (status byte, upper nibble)
  localparam logic [7:0] KIND_MASK  = 8'hF0;
  localparam logic [7:0] CHAN_MASK  = 8'h0F;
  localparam logic [7:0] KIND_CTRL  = 8'hB0;
  localparam logic [7:0] KIND_BEND  = 8'hE0;
  localparam logic [7:0] KIND_KEYP  = 8'hA0;
  localparam logic [7:0] KIND_CHANP = 8'hD0;

  // Commands
  localparam logic CMD_MESSAGE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_PASSED     = 3'd0;
  localparam logic [2:0] ST_CACHED     = 3'd1;
  localparam logic [2:0] ST_READ_OK    = 3'd2;
  localparam logic [2:0] ST_BAD_STREAM = 3'd3;
  localparam logic [2:0] ST_BAD_RANGE  = 3'd4;
  localparam logic [2:0] ST_CACHE_OFF  = 3'd5;

  // Configuration register indexes
  localparam logic REG_CACHE_ENABLE = 1'b0;
  localparam logic REG_STREAM_COUNT = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [STREAM_W-1:0] stream;
    logic [23:0]         message;
    logic [ENTRY_W-1:0]  entry_index;
    logic [ENTRY_W-1:0]  first_index;
    logic [ENTRY_W-1:0]  last_index;
  } req_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [23:0]        message_out;
    logic [VALUE_W-1:0] value;
    logic [ENTRY_W-1:0] count;
    logic               last;
  } rsp_word_t;

  // Table write request from the decoder to the store
  typedef struct packed {
    logic               en;
    logic [MEM_AW-1:0]  addr;
    logic [VALUE_W-1:0] data;
  } wr_req_t;

endpackage

[rtl/midi_controller_cache_top.sv]
// Top level of the MIDI controller value cache.
`timescale 1ns / 1ps

// Takes one word per cycle on req while req_stall is low and returns exactly one
// word per request on rsp, in order; each word passes the stage 1 register and
// then the output register, and is taken when rsp is not stalled. All tables
// live in one memory of NUM_STREAMS*512 slots of 16 bits; after reset the block
// sweeps it to zero, one slot a cycle, and holds req_stall high until the sweep
// is done. Configuration writes are always taken (cfg_ready stays high) and
// should only be issued while idle. Control change, key pressure, channel
// pressure and pitch bend messages on a live stream are absorbed into the
// tables while cache_enable is set; other messages on a live stream pass.

module midi_controller_cache_top
  import mcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_word_t  req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_word_t  rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data
);

  logic       cache_enable;
  logic [2:0] stream_count;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_enable <= 1'b0;
      stream_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CACHE_ENABLE: cache_enable <= cfg_data[0];
        REG_STREAM_COUNT: stream_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode the request
  logic [7:0]         kind;
  logic [3:0]         chan;
  logic [7:0]         d1;
  logic [7:0]         d2;
  logic               stream_ok;
  logic               range_bad;
  logic [ENTRY_W-1:0] wr_entry;
  logic [VALUE_W-1:0] wr_data;
  logic               is_cached;
  logic               is_read_ok;
  rsp_word_t          res;

  assign kind = req.message[7:0] & KIND_MASK;
  assign chan = 4'(req.message[7:0] & CHAN_MASK);
  assign d1   = req.message[15:8];
  assign d2   = req.message[23:16];

  assign stream_ok = ({1'b0, req.stream} < stream_count) && (32'(req.stream) < NUM_STREAMS);
  assign range_bad = (req.first_index > req.last_index) || (req.last_index > ENTRY_MAX)
                  || (req.entry_index < req.first_index)
                  || (req.entry_index > req.last_index);

  always_comb begin
    is_cached = cache_enable;
    wr_entry  = {2'b00, d1[6:0]};
    wr_data   = {8'h00, d2};
    case (kind)
      KIND_CTRL: begin
        wr_entry = {2'b00, d1[6:0]};
      end
      KIND_KEYP: begin
        wr_entry = ENTRY_KEY + {2'b00, d1[6:0]};
      end
      KIND_CHANP: begin
        wr_entry = ENTRY_CHAN + {5'b0, chan};
        wr_data  = {8'h00, d1};
      end
      KIND_BEND: begin
        wr_entry = ENTRY_BEND + {5'b0, chan};
        wr_data  = {1'b0, d2, 7'b0} + {8'h00, d1};
      end
      default: is_cached = 1'b0;
    endcase
  end

  // Form the result, all but the table value
  always_comb begin
    res        = '0;
    is_read_ok = 1'b0;
    if (req.cmd == CMD_MESSAGE) begin
      if (!stream_ok) begin
        res.status = ST_BAD_STREAM;
      end else if (is_cached) begin
        res.status = ST_CACHED;
      end else begin
        res.status      = ST_PASSED;
        res.message_out = req.message;
      end
    end else if (!cache_enable) begin
      res.status = ST_CACHE_OFF;
    end else if (!stream_ok) begin
      res.status = ST_BAD_STREAM;
    end else if (range_bad) begin
      res.status = ST_BAD_RANGE;
    end else begin
      is_read_ok = 1'b1;
      res.status = ST_READ_OK;
      res.count  = req.last_index - req.first_index + 1'b1;
      res.last   = (req.entry_index == req.last_index);
    end
  end

  // Pipeline control: stage 1 waits for the table read, then the output register
  logic      req_accept;
  logic      s1_valid;
  rsp_word_t s1_res;
  logic      s1_use_rd;
  logic      s1_advance;
  logic      store_busy;
  rsp_word_t rsp_next;

  assign s1_advance = !rsp_valid || !rsp_stall;
  assign req_stall  = store_busy || (s1_valid && !s1_advance);
  assign req_accept = req_valid && !req_stall;

  // Table access
  wr_req_t            wr;
  logic [VALUE_W-1:0] rd_data;
  logic [MEM_AW-1:0]  rd_addr;

  assign wr.en   = req_accept && (req.cmd == CMD_MESSAGE) && stream_ok && is_cached;
  assign wr.addr = MEM_AW'({req.stream, wr_entry});
  assign wr.data = wr_data;
  assign rd_addr = MEM_AW'({req.stream, req.entry_index});

  mcc_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_en   (req_accept && is_read_ok),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (store_busy)
  );

  // Advance stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      s1_res    <= res;
      s1_use_rd <= is_read_ok;
    end
  end

  // Merge the table value into the stage 1 word
  always_comb begin
    rsp_next       = s1_res;
    rsp_next.value = s1_use_rd ? rd_data : '0;
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

[rtl/mcc_store.sv]
// Table store of the controller cache: one memory with a clearing sweep after reset.
`timescale 1ns / 1ps

module mcc_store
  import mcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  wr_req_t            wr,
  input  logic               rd_en,
  input  logic [MEM_AW-1:0]  rd_addr,
  output logic [VALUE_W-1:0] rd_data,
  output logic               busy
);

  logic [VALUE_W-1:0] mem [MEM_DEPTH];

  logic              clearing;
  logic [MEM_AW-1:0] clear_addr;

  // Sweep every slot to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == MEM_AW'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clear_addr <= clear_addr + 1'b1;
    end
  end

  // Single write port: the sweep owns it while clearing
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_addr] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read, sees writes of earlier edges
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign busy = clearing;

endmodule

[rtl/mcc_checker.sv]
// Port checker for the MIDI controller value cache, bound to the top level.
`timescale 1ns / 1ps

module mcc_checker
  import mcc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_stall,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_word_t rsp
);

  // Tables are swept after reset, so requests must wait
  a_stall_after_reset: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request taken during table sweep");

  // No word survives reset
  a_idle_after_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // A stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response word changed");

  // Only a passed message carries a message
  a_msg_only_passed: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_PASSED |-> rsp.message_out == '0)
    else $error("message on a word that did not pass");

  // Read fields stay zero unless the read succeeded
  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_READ_OK |-> rsp.value == '0 && rsp.count == '0 && !rsp.last)
    else $error("read fields set on a word that is not a good read");

endmodule

bind midi_controller_cache_top mcc_checker u_mcc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

[verif/tb.sv]
// Self-checking testbench for the MIDI controller value cache top level.
`timescale 1ns / 1ps

module tb
  import mcc_pkg::*;
();

  localparam int IDLE_LIMIT  = 12000;
  localparam int RAND_PHASES = 7;
  localparam int RAND_ITEMS  = 200;

  logic      clk;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = REG_CACHE_ENABLE;
  logic [2:0] cfg_data = '0;

  midi_controller_cache_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block's tables and registers
  logic [7:0]  ctrl_tbl  [0:NUM_STREAMS*128-1];
  logic [7:0]  keyp_tbl  [0:NUM_STREAMS*128-1];
  logic [7:0]  chanp_tbl [0:NUM_STREAMS*16-1];
  logic [15:0] bend_tbl  [0:NUM_STREAMS*16-1];
  logic        cache_on;
  logic [2:0]  live_streams;

  req_word_t requests_waiting [$];
  rsp_word_t replies_due [$];

  int   reqs_taken   = 0;
  int   words_seen   = 0;
  int   mismatches   = 0;
  int   settings_run = 0;
  int   status_seen [0:7];
  logic calm;

  // Hold both sides free of idling for a long stretch in mid-run
  assign calm = (reqs_taken >= 600) && (reqs_taken < 950);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < 40)
      $display("MISMATCH %s: got %0h, want %0h (word %0d)", what, got, want, words_seen);
    mismatches++;
  endtask

  function automatic bit stream_live(logic [STREAM_W-1:0] s);
    return (int'(s) < int'(live_streams)) && (int'(s) < NUM_STREAMS);
  endfunction

  // Work out the reply to one request and apply its table write
  function automatic rsp_word_t cache_reply(req_word_t w);
    rsp_word_t   r;
    logic [7:0]  kind;
    logic [3:0]  chan;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [ENTRY_W-1:0] e;
    r    = '0;
    kind = w.message[7:0] & KIND_MASK;
    chan = w.message[3:0];
    d1   = w.message[15:8];
    d2   = w.message[23:16];
    e    = w.entry_index;
    if (w.cmd == CMD_MESSAGE) begin
      if (!stream_live(w.stream)) begin
        r.status = ST_BAD_STREAM;
      end else begin
        r.status = ST_CACHED;
        if (cache_on && kind == KIND_CTRL)
          ctrl_tbl[{w.stream, d1[6:0]}] = d2;
        else if (cache_on && kind == KIND_BEND)
          bend_tbl[{w.stream, chan}] = 16'(({8'h00, d2} << 7) + {8'h00, d1});
        else if (cache_on && kind == KIND_KEYP)
          keyp_tbl[{w.stream, d1[6:0]}] = d2;
        else if (cache_on && kind == KIND_CHANP)
          chanp_tbl[{w.stream, chan}] = d1;
        else begin
          r.status      = ST_PASSED;
          r.message_out = w.message;
        end
      end
    end else if (!cache_on) begin
      r.status = ST_CACHE_OFF;
    end else if (!stream_live(w.stream)) begin
      r.status = ST_BAD_STREAM;
    end else if (w.first_index > w.last_index || w.last_index > ENTRY_MAX ||
                 e < w.first_index || e > w.last_index) begin
      r.status = ST_BAD_RANGE;
    end else begin
      r.status = ST_READ_OK;
      if (e < ENTRY_KEY)
        r.value = {8'h00, ctrl_tbl[{w.stream, e[6:0]}]};
      else if (e < ENTRY_CHAN)
        r.value = {8'h00, keyp_tbl[{w.stream, e[6:0]}]};
      else if (e < ENTRY_BEND)
        r.value = {8'h00, chanp_tbl[{w.stream, e[3:0]}]};
      else
        r.value = bend_tbl[{w.stream, 4'(e - ENTRY_BEND)}];
      r.count = w.last_index - w.first_index + 9'd1;
      r.last  = (e == w.last_index);
    end
    return r;
  endfunction

  function automatic req_word_t midi_word(logic [1:0] s, logic [7:0] st, logic [7:0] d1,
                                          logic [7:0] d2);
    req_word_t w;
    w             = req_word_t'({$urandom, $urandom});
    w.cmd         = CMD_MESSAGE;
    w.stream      = s;
    w.message     = {d2, d1, st};
    return w;
  endfunction

  function automatic req_word_t read_word(logic [1:0] s, int e, int f, int l);
    req_word_t w;
    w             = req_word_t'({$urandom, $urandom});
    w.cmd         = CMD_READ;
    w.stream      = s;
    w.entry_index = ENTRY_W'(e);
    w.first_index = ENTRY_W'(f);
    w.last_index  = ENTRY_W'(l);
    return w;
  endfunction

  // Mostly well-formed traffic on live streams, around a few hot table slots
  function automatic req_word_t random_request();
    req_word_t  w;
    logic [1:0] s;
    logic [7:0] st;
    logic [7:0] d1;
    int         live;
    int         pick;
    int         e;
    int         region;
    w    = req_word_t'({$urandom, $urandom});
    live = (int'(live_streams) > NUM_STREAMS) ? NUM_STREAMS : int'(live_streams);
    if (live > 0 && $urandom_range(9) != 0)
      s = 2'($urandom_range(live - 1, 0));
    else
      s = 2'($urandom);
    pick = $urandom_range(99);
    if (pick < 15)
      return w;
    if (pick < 60) begin
      case ($urandom_range(4))
        0: st = KIND_CTRL;
        1: st = KIND_BEND;
        2: st = KIND_KEYP;
        3: st = KIND_CHANP;
        default: st = 8'($urandom);
      endcase
      st[3:0] = 4'($urandom);
      if ($urandom_range(1) != 0)
        d1 = {1'($urandom), 4'b0000, 3'($urandom)};
      else
        d1 = 8'($urandom);
      return midi_word(s, st, d1, 8'($urandom));
    end
    region = $urandom_range(4);
    case (region)
      0: e = $urandom_range(7);
      1: e = int'(ENTRY_KEY) + $urandom_range(7);
      2: e = int'(ENTRY_CHAN) + $urandom_range(15);
      3: e = int'(ENTRY_BEND) + $urandom_range(15);
      default: e = $urandom_range(int'(ENTRY_MAX));
    endcase
    if ($urandom_range(99) < 85) begin
      if ($urandom_range(9) == 0)
        return read_word(s, e, 0, int'(ENTRY_MAX));
      return read_word(s, e, $urandom_range(e, 0), $urandom_range(int'(ENTRY_MAX), e));
    end
    w.cmd    = CMD_READ;
    w.stream = s;
    return w;
  endfunction

  // Wait until every request is taken and every reply has come back
  task automatic drain();
    while (requests_waiting.size() != 0 || req_valid || replies_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [2:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_CACHE_ENABLE)
      cache_on = data[0];
    else
      live_streams = data;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(logic en, logic [2:0] streams);
    drain();
    write_reg(REG_CACHE_ENABLE, {2'b00, en});
    write_reg(REG_STREAM_COUNT, streams);
    settings_run++;
  endtask

  // Driver: present the next pending word once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (req_valid) begin
        replies_due.push_back(cache_reply(req));
        reqs_taken++;
      end
      if (requests_waiting.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
        req       <= requests_waiting.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each reply word against the oldest prediction
  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        words_seen++;
        if (replies_due.size() == 0) begin
          note_mismatch("unexpected word, status", rsp.status, 0);
        end else begin
          want = replies_due.pop_front();
          status_seen[want.status]++;
          if (rsp.status !== want.status)
            note_mismatch("status", rsp.status, want.status);
          if (rsp.message_out !== want.message_out)
            note_mismatch("message_out", rsp.message_out, want.message_out);
          if (rsp.value !== want.value)
            note_mismatch("value", rsp.value, want.value);
          if (rsp.count !== want.count)
            note_mismatch("count", rsp.count, want.count);
          if (rsp.last !== want.last)
            note_mismatch("last", rsp.last, want.last);
        end
      end
      rsp_stall <= !calm && ($urandom_range(99) < 8);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    int idle_cycles;
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("** midi_controller_cache_top: FAILED **");
      $finish;
    end
  end

  initial begin
    logic       en_set  [0:RAND_PHASES-1];
    logic [2:0] cnt_set [0:RAND_PHASES-1];
    en_set  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    cnt_set = '{3'd4, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd4};
    for (int i = 0; i < NUM_STREAMS * 128; i++) begin
      ctrl_tbl[i] = '0;
      keyp_tbl[i] = '0;
    end
    for (int i = 0; i < NUM_STREAMS * 16; i++) begin
      chanp_tbl[i] = '0;
      bend_tbl[i]  = '0;
    end
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    cache_on     = 1'b0;
    live_streams = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: no live stream, caching off
    requests_waiting.push_back(midi_word(2'd0, KIND_CTRL, 8'h01, 8'h22));
    requests_waiting.push_back(read_word(2'd0, 0, 0, 0));

    // Table writes at the edges of each field and messages that pass, then reads of every region
    set_mode(1'b1, 3'd4);
    requests_waiting.push_back(midi_word(2'd0, KIND_CTRL, 8'hFF, 8'hFF));
    requests_waiting.push_back(midi_word(2'd3, KIND_CTRL, 8'h00, 8'h5A));
    requests_waiting.push_back(midi_word(2'd1, KIND_KEYP, 8'h80, 8'hFF));
    requests_waiting.push_back(midi_word(2'd2, KIND_CHANP | 8'h0F, 8'hFF, 8'h33));
    requests_waiting.push_back(midi_word(2'd3, KIND_BEND, 8'hFF, 8'hFF));
    requests_waiting.push_back(midi_word(2'd0, KIND_BEND | 8'h0F, 8'h00, 8'h40));
    requests_waiting.push_back(midi_word(2'd1, 8'h90, 8'h3C, 8'h64));
    requests_waiting.push_back(midi_word(2'd2, 8'hFF, 8'hFF, 8'hFF));
    requests_waiting.push_back(midi_word(2'd3, 8'h00, 8'h00, 8'h00));
    requests_waiting.push_back(read_word(2'd0, 127, 0, int'(ENTRY_MAX)));
    requests_waiting.push_back(read_word(2'd3, 0, 0, 0));
    requests_waiting.push_back(read_word(2'd1, 128, 128, 255));
    requests_waiting.push_back(read_word(2'd2, 271, 256, 271));
    requests_waiting.push_back(read_word(2'd3, 272, 272, 287));
    requests_waiting.push_back(read_word(2'd0, 287, 287, 287));
    // Broken ranges: reversed, past the map, entry outside the range
    requests_waiting.push_back(read_word(2'd0, 10, 11, 10));
    requests_waiting.push_back(read_word(2'd1, 288, 288, 288));
    requests_waiting.push_back(read_word(2'd2, 5, 6, 9));
    requests_waiting.push_back(read_word(2'd3, 300, 0, int'(ENTRY_MAX)));

    // Fewer live streams than ports
    set_mode(1'b1, 3'd2);
    requests_waiting.push_back(read_word(2'd2, 0, 0, 0));
    requests_waiting.push_back(midi_word(2'd3, KIND_CTRL, 8'h05, 8'h77));
    requests_waiting.push_back(read_word(2'd1, 128, 0, int'(ENTRY_MAX)));

    // Caching off: everything passes, reads refused
    set_mode(1'b0, 3'd4);
    requests_waiting.push_back(midi_word(2'd0, KIND_CTRL, 8'h07, 8'h11));
    requests_waiting.push_back(read_word(2'd3, 7, 0, 7));

    for (int p = 0; p < RAND_PHASES; p++) begin
      set_mode(en_set[p], cnt_set[p]);
      for (int i = 0; i < RAND_ITEMS; i++)
        requests_waiting.push_back(random_request());
    end

    drain();
    repeat (8) @(posedge clk);
    if (replies_due.size() != 0)
      note_mismatch("replies never returned", replies_due.size(), 0);
    $display("Run covered %0d requests over %0d cache settings; %0d replies checked",
             reqs_taken, settings_run, words_seen);
    $display("  cached %0d, passed %0d, reads %0d, bad stream %0d, bad range %0d, off %0d",
             status_seen[ST_CACHED], status_seen[ST_PASSED], status_seen[ST_READ_OK],
             status_seen[ST_BAD_STREAM], status_seen[ST_BAD_RANGE],
             status_seen[ST_CACHE_OFF]);
    if (mismatches == 0) begin
      $display("** midi_controller_cache_top: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** midi_controller_cache_top: FAILED **");
    end
    $finish;
  end

endmodule
